@@ src/matrix3_inverse_defines.svh @@
// Assertion macros for the matrix inverse block.
`ifndef MATRIX3_INVERSE_DEFINES_SVH
`define MATRIX3_INVERSE_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define M3I_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define M3I_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

@@ src/m3i_pkg.sv @@
package m3i_pkg;
   localparam int ELEMENT_WIDTH_DEF = 16;
   localparam int FRACTION_BITS_DEF = 8;
   localparam int OUT_FRAC = 16;
   localparam int OUT_W = 32;
   localparam int QBITS = OUT_W + 1;
   localparam int DIV_LAT = QBITS + 2;

   typedef struct packed {
      logic [OUT_W-1:0] q;
      logic             sat;
   } div_out_type;
endpackage

@@ src/m3i_div.sv @@
module m3i_div #(
   parameter int NUM_W = 33,
   parameter int DEN_W = 50,
   parameter int SHIFT = 24
) (
   input  logic                clock,
   input  logic [NUM_W-1:0]    num,
   input  logic                neg,
   input  logic [DEN_W-1:0]    den,
   output m3i_pkg::div_out_type result
);
   import m3i_pkg::*;

   localparam int WA = NUM_W + SHIFT;
   localparam int WB = DEN_W + QBITS;
   localparam int W = ((WA > WB) ? WA : WB) + 1;
   localparam logic [QBITS-1:0] NEG_LIM = QBITS'(1) << (OUT_W - 1);
   localparam logic [QBITS-1:0] POS_LIM = NEG_LIM - QBITS'(1);

   logic [W-1:0]     rem_ff [0:QBITS];
   logic [QBITS-1:0] q_ff   [0:QBITS];
   logic [DEN_W-1:0] den_ff [0:QBITS];
   logic             neg_ff [0:QBITS];
   logic             sat_ff [0:QBITS];
   logic [W-1:0]     num_sh;
   div_out_type      result_in;
   div_out_type      result_ff;

   assign num_sh = W'(num) << SHIFT;

   always_ff @(posedge clock) begin
      rem_ff[0] <= num_sh;
      q_ff[0]   <= '0;
      den_ff[0] <= den;
      neg_ff[0] <= neg;
      sat_ff[0] <= num_sh >= (W'(den) << QBITS);
   end

   for (genvar i = 0; i < QBITS; i++) begin : g_step
      localparam int K = QBITS - 1 - i;
      logic [W-1:0] trial;
      assign trial = W'(den_ff[i]) << K;
      always_ff @(posedge clock) begin
         if (rem_ff[i] >= trial) begin
            rem_ff[i+1] <= rem_ff[i] - trial;
            q_ff[i+1]   <= q_ff[i] | (QBITS'(1) << K);
         end else begin
            rem_ff[i+1] <= rem_ff[i];
            q_ff[i+1]   <= q_ff[i];
         end
         den_ff[i+1] <= den_ff[i];
         neg_ff[i+1] <= neg_ff[i];
         sat_ff[i+1] <= sat_ff[i];
      end
   end

   always_comb begin
      result_in.sat = sat_ff[QBITS];
      if (neg_ff[QBITS]) begin
         if (sat_ff[QBITS] || q_ff[QBITS] > NEG_LIM) begin
            result_in.sat = 1'b1;
            result_in.q   = OUT_W'(NEG_LIM);
         end else begin
            result_in.q   = OUT_W'(QBITS'(0) - q_ff[QBITS]);
         end
      end else begin
         if (sat_ff[QBITS] || q_ff[QBITS] > POS_LIM) begin
            result_in.sat = 1'b1;
            result_in.q   = OUT_W'(POS_LIM);
         end else begin
            result_in.q   = OUT_W'(q_ff[QBITS]);
         end
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign result = result_ff;
endmodule

@@ src/matrix3_inverse.sv @@
// Pipelined 3x3 matrix inverse, signed fixed point in, signed Q16.16 out.
// Input: drive req_a00..req_a22 with req_start high; the transaction is taken at
// any clock edge where req_start is high and busy is low. busy stays low, so a
// new matrix may enter every cycle.
// Output: rsp_valid strobes high for one cycle with rsp_b00..rsp_b22,
// rsp_singular and rsp_saturated; the receiver must take it in that cycle.
// The pipeline has five stages for cofactors and determinant, then a restoring
// divider with one quotient bit per stage (33 bits) plus a precheck and a clip
// stage, one per entry. Throughput is one matrix per cycle.
// A zero determinant gives zero entries with rsp_singular set; a clipped
// entry sets rsp_saturated.
// Reset clears all valid bits in the pipeline; data in flight is dropped.
`include "matrix3_inverse_defines.svh"

module matrix3_inverse #(
   parameter int ELEMENT_WIDTH = m3i_pkg::ELEMENT_WIDTH_DEF,
   parameter int FRACTION_BITS = m3i_pkg::FRACTION_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_start,
   output logic                            busy,
   input  logic signed [ELEMENT_WIDTH-1:0] req_a00,
   input  logic signed [ELEMENT_WIDTH-1:0] req_a01,
   input  logic signed [ELEMENT_WIDTH-1:0] req_a02,
   input  logic signed [ELEMENT_WIDTH-1:0] req_a10,
   input  logic signed [ELEMENT_WIDTH-1:0] req_a11,
   input  logic signed [ELEMENT_WIDTH-1:0] req_a12,
   input  logic signed [ELEMENT_WIDTH-1:0] req_a20,
   input  logic signed [ELEMENT_WIDTH-1:0] req_a21,
   input  logic signed [ELEMENT_WIDTH-1:0] req_a22,
   output logic                            rsp_valid,
   output logic signed [m3i_pkg::OUT_W-1:0] rsp_b00,
   output logic signed [m3i_pkg::OUT_W-1:0] rsp_b01,
   output logic signed [m3i_pkg::OUT_W-1:0] rsp_b02,
   output logic signed [m3i_pkg::OUT_W-1:0] rsp_b10,
   output logic signed [m3i_pkg::OUT_W-1:0] rsp_b11,
   output logic signed [m3i_pkg::OUT_W-1:0] rsp_b12,
   output logic signed [m3i_pkg::OUT_W-1:0] rsp_b20,
   output logic signed [m3i_pkg::OUT_W-1:0] rsp_b21,
   output logic signed [m3i_pkg::OUT_W-1:0] rsp_b22,
   output logic                            rsp_singular,
   output logic                            rsp_saturated
);
   import m3i_pkg::*;

   localparam int E = ELEMENT_WIDTH;
   localparam int PW = 2 * E;
   localparam int CW = 2 * E + 1;
   localparam int DPW = E + CW;
   localparam int DETW = DPW + 2;
   localparam int LAT = 5 + DIV_LAT;

   logic signed [E-1:0]    a_in   [3][3];
   logic signed [E-1:0]    a_ff   [3][3];
   logic signed [PW-1:0]   pa_ff  [3][3];
   logic signed [PW-1:0]   pb_ff  [3][3];
   logic signed [E-1:0]    r0a_ff [3];
   logic signed [E-1:0]    r0b_ff [3];
   logic signed [CW-1:0]   cof_ff [3][3];
   logic signed [CW-1:0]   cofd_ff[3][3];
   logic signed [CW-1:0]   cofe_ff[3][3];
   logic signed [DPW-1:0]  dp_ff  [3];
   logic signed [DETW-1:0] det_ff;
   logic [LAT-1:0]         val_ff;
   logic [DIV_LAT-1:0]     sing_ff;
   logic                   det_neg;
   logic [DETW-1:0]        det_mag;
   div_out_type            dres   [3][3];
   logic [OUT_W-1:0]       b_out  [3][3];
   logic [8:0]             sat_vec;

   assign a_in[0][0] = req_a00;
   assign a_in[0][1] = req_a01;
   assign a_in[0][2] = req_a02;
   assign a_in[1][0] = req_a10;
   assign a_in[1][1] = req_a11;
   assign a_in[1][2] = req_a12;
   assign a_in[2][0] = req_a20;
   assign a_in[2][1] = req_a21;
   assign a_in[2][2] = req_a22;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff <= '0;
      end else begin
         val_ff <= {val_ff[LAT-2:0], req_start};
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      r0a_ff  <= a_ff[0];
      r0b_ff  <= r0a_ff;
      cofd_ff <= cof_ff;
      cofe_ff <= cofd_ff;
      det_ff  <= DETW'(dp_ff[0]) + DETW'(dp_ff[1]) + DETW'(dp_ff[2]);
      sing_ff <= {sing_ff[DIV_LAT-2:0], det_ff == '0};
   end

   for (genvar i = 0; i < 3; i++) begin : g_row
      for (genvar j = 0; j < 3; j++) begin : g_col
         localparam int R1 = (i + 1) % 3;
         localparam int R2 = (i + 2) % 3;
         localparam int C1 = (j + 1) % 3;
         localparam int C2 = (j + 2) % 3;
         always_ff @(posedge clock) begin
            pa_ff[i][j]  <= a_ff[R1][C1] * a_ff[R2][C2];
            pb_ff[i][j]  <= a_ff[R1][C2] * a_ff[R2][C1];
            cof_ff[i][j] <= CW'(pa_ff[i][j]) - CW'(pb_ff[i][j]);
         end
      end
   end

   for (genvar j = 0; j < 3; j++) begin : g_detp
      always_ff @(posedge clock) begin
         dp_ff[j] <= r0b_ff[j] * cof_ff[0][j];
      end
   end

   assign det_neg = det_ff[DETW-1];
   assign det_mag = det_neg ? DETW'(-det_ff) : DETW'(det_ff);

   for (genvar i = 0; i < 3; i++) begin : g_out_row
      for (genvar j = 0; j < 3; j++) begin : g_out_col
         logic          c_neg;
         logic [CW-1:0] c_mag;
         assign c_neg = cofe_ff[j][i][CW-1];
         assign c_mag = c_neg ? CW'(-cofe_ff[j][i]) : CW'(cofe_ff[j][i]);
         m3i_div #(
            .NUM_W (CW),
            .DEN_W (DETW),
            .SHIFT (FRACTION_BITS + OUT_FRAC)
         ) u_div (
            .clock  (clock),
            .num    (c_mag),
            .neg    (c_neg ^ det_neg),
            .den    (det_mag),
            .result (dres[i][j])
         );
         assign b_out[i][j]     = sing_ff[DIV_LAT-1] ? '0 : dres[i][j].q;
         assign sat_vec[i*3+j]  = dres[i][j].sat;
      end
   end

   assign rsp_valid     = val_ff[LAT-1];
   assign rsp_singular  = sing_ff[DIV_LAT-1];
   assign rsp_saturated = !sing_ff[DIV_LAT-1] && (|sat_vec);
   assign rsp_b00 = b_out[0][0];
   assign rsp_b01 = b_out[0][1];
   assign rsp_b02 = b_out[0][2];
   assign rsp_b10 = b_out[1][0];
   assign rsp_b11 = b_out[1][1];
   assign rsp_b12 = b_out[1][2];
   assign rsp_b20 = b_out[2][0];
   assign rsp_b21 = b_out[2][1];
   assign rsp_b22 = b_out[2][2];

   `M3I_ALWAYS(a_never_busy, !busy, "busy raised")
   `M3I_IMPLY(a_valid_from_start, rsp_valid, $past(req_start, LAT), "result without transaction")
   `M3I_IMPLY(a_singular_clean, rsp_valid && rsp_singular,
      !rsp_saturated && rsp_b11 == '0, "singular result not cleared")
endmodule
